// ----- hw/rtl/login_reply_frame_check_defines.svh -----
// Assertion macros for the login reply frame checker.
`ifndef LOGIN_REPLY_FRAME_CHECK_DEFINES_SVH
`define LOGIN_REPLY_FRAME_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
`define LRFC_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define LRFC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define LRFC_ASSERT_SAME(label, pre, post, msg)
`define LRFC_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- hw/rtl/lrfc_pkg.sv -----
// Types, constants and helper functions for the login reply frame checker.
package lrfc_pkg;

    localparam int CHAR_W       = 8;
    localparam int COUNT_W      = 9;
    localparam int COUNT_SAT    = 511;
    localparam int WIN_DEPTH    = 7;
    localparam int HEX_DEPTH    = 4;
    localparam int FIELD_END    = 23;
    localparam int MIN_BODY     = 27;
    localparam int MAX_BODY_DEF = 262;
    localparam int POS_W        = 5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_TWO   = 8'h32;
    localparam logic [CHAR_W-1:0] CH_THREE = 8'h33;
    localparam logic [CHAR_W-1:0] CH_FOUR  = 8'h34;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    // body positions with special handling
    localparam logic [POS_W-1:0] POS_LEN_FIRST = 5'd8;
    localparam logic [POS_W-1:0] POS_LEN_LAST  = 5'd11;
    localparam logic [POS_W-1:0] POS_UNIT      = 5'd12;
    localparam logic [POS_W-1:0] POS_FUNC_LO   = 5'd14;

    localparam logic [2:0] MODE_NONE = 3'd0;
    localparam logic [2:0] MODE_P    = 3'd1;
    localparam logic [2:0] MODE_E    = 3'd2;
    localparam logic [2:0] MODE_I    = 3'd3;
    localparam logic [2:0] MODE_A    = 3'd4;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_NO_FRAME = 4'd1,
        ERR_SHORT    = 4'd2,
        ERR_LONG     = 4'd3,
        ERR_CRC      = 4'd4,
        ERR_TRANS    = 4'd5,
        ERR_PROTO    = 4'd6,
        ERR_LENGTH   = 4'd7,
        ERR_UNIT     = 4'd8,
        ERR_FUNC     = 4'd9,
        ERR_FIRST    = 4'd10,
        ERR_COUNT    = 4'd11
    } err_t;

    // classified character as it travels from front to back
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              colon;
        logic              hex_ok;
        logic [3:0]        hex_val;
        logic [2:0]        mode;
    } char_info_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_digit_t;

    typedef struct packed {
        logic       frame_ok;
        err_t       error_code;
        logic [2:0] unit_mode;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [CHAR_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {{8{b[7]}}, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_digit_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end
        else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [2:0] unit_decode(input logic [CHAR_W-1:0] c);
        logic [2:0] m;
        unique case (c)
            8'h50:   m = MODE_P;
            8'h45:   m = MODE_E;
            8'h49:   m = MODE_I;
            8'h41:   m = MODE_A;
            default: m = MODE_NONE;
        endcase
        return m;
    endfunction

    // fixed character expected at a header position, CH_NONE where none is fixed
    function automatic logic [CHAR_W-1:0] expect_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] e;
        unique case (pos) inside
            5'd0, 5'd1, 5'd2, 5'd4, 5'd5, 5'd6, 5'd7,
            5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd22: e = CH_ZERO;
            5'd3:    e = CH_ONE;
            5'd21:   e = CH_TWO;
            default: e = CH_NONE;
        endcase
        return e;
    endfunction

    function automatic err_t field_err(input logic [POS_W-1:0] pos);
        err_t e;
        if (pos < 5'd4) begin
            e = ERR_TRANS;
        end
        else if (pos < 5'd8) begin
            e = ERR_PROTO;
        end
        else if (pos < 5'd19) begin
            e = ERR_FIRST;
        end
        else begin
            e = ERR_COUNT;
        end
        return e;
    endfunction

endpackage

// ----- hw/rtl/lrfc_front.sv -----
// Front end: accepts received characters and classifies them for the back end.
module lrfc_front
    import lrfc_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // rx_char[7:0]
    input  logic              s_tlast,   // block_end
    input  logic              q_full,
    output logic              q_push,
    output char_info_t        q_wr_data
);

    hex_digit_t hex;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign hex      = hex_decode(s_tdata);

    always_comb
    begin
        q_wr_data.ch      = s_tdata;
        q_wr_data.last    = s_tlast;
        q_wr_data.colon   = (s_tdata == CH_COLON);
        q_wr_data.hex_ok  = hex.ok;
        q_wr_data.hex_val = hex.val;
        q_wr_data.mode    = unit_decode(s_tdata);
    end

endmodule

// ----- hw/rtl/lrfc_queue.sv -----
// Two-entry queue of classified characters between front and back end.
module lrfc_queue
    import lrfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  char_info_t wr_data,
    output logic       full,
    input  logic       pop,
    output logic       valid,
    output char_info_t rd_data
);

    char_info_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/lrfc_back.sv -----
// Back end: frame tracking, CRC, field checks and the result register.
module lrfc_back
    import lrfc_pkg::*;
#(
    parameter int MAX_BODY_CHARS = MAX_BODY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  char_info_t q_rd_data,
    output logic       q_pop,
    output logic       res_valid,
    input  logic       res_ready,
    output result_t    res
);

    phase_t            phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]       crc_reg, crc_next;
    logic [CHAR_W-1:0] win_reg [WIN_DEPTH];
    logic [CHAR_W-1:0] win_next [WIN_DEPTH];
    hex_digit_t        hexw_reg [HEX_DEPTH];
    hex_digit_t        hexw_next [HEX_DEPTH];
    logic [15:0]       len_reg, len_next;
    logic              len_bad_reg, len_bad_next;
    err_t              ferr_reg, ferr_next;
    logic [2:0]        mode_reg, mode_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    char_info_t        in;
    logic              body;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] exp_ch;
    logic              func_ok;
    logic [15:0]       rx_crc;
    logic              rx_crc_ok;
    err_t              err;

    assign in        = q_rd_data;
    // a result only waits on the output slot; other characters always drain
    assign q_pop     = q_valid && (!in.last || !out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign pos       = count_reg[POS_W-1:0];
    assign exp_ch    = expect_char(pos);

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        win_next     = win_reg;
        hexw_next    = hexw_reg;
        len_next     = len_reg;
        len_bad_next = len_bad_reg;
        ferr_next    = ferr_reg;
        mode_next    = mode_reg;
        body         = 1'b0;
        func_ok      = 1'b0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (in.colon)
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (in.colon)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    body = 1'b1;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        if (body)
        begin
            // CRC trails the body by the window depth
            if (count_reg >= COUNT_W'(WIN_DEPTH))
            begin
                crc_next = crc_byte(crc_reg, win_reg[0]);
            end
            if (count_reg < COUNT_W'(FIELD_END))
            begin
                if (exp_ch != CH_NONE)
                begin
                    if (in.ch != exp_ch && ferr_reg == ERR_OK)
                    begin
                        ferr_next = field_err(pos);
                    end
                end
                else if (pos >= POS_LEN_FIRST && pos <= POS_LEN_LAST)
                begin
                    if (!in.hex_ok)
                    begin
                        len_bad_next = 1'b1;
                    end
                    else
                    begin
                        len_next = {len_reg[11:0], in.hex_val};
                    end
                end
                else if (pos == POS_UNIT)
                begin
                    mode_next = in.mode;
                    if (in.mode == MODE_NONE && ferr_reg == ERR_OK)
                    begin
                        ferr_next = ERR_UNIT;
                    end
                end
                else if (pos == POS_FUNC_LO)
                begin
                    func_ok = (win_reg[WIN_DEPTH-1] == CH_ONE && in.ch == CH_ZERO) ||
                              (win_reg[WIN_DEPTH-1] == CH_ZERO &&
                               (in.ch == CH_THREE || in.ch == CH_FOUR));
                    if (!func_ok && ferr_reg == ERR_OK)
                    begin
                        ferr_next = ERR_FUNC;
                    end
                end
            end
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WIN_DEPTH-1] = in.ch;
            for (int i = 0; i < HEX_DEPTH - 1; i++)
            begin
                hexw_next[i] = hexw_reg[i+1];
            end
            hexw_next[HEX_DEPTH-1].ok  = in.hex_ok;
            hexw_next[HEX_DEPTH-1].val = in.hex_val;
            if (count_reg != COUNT_W'(COUNT_SAT))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // end-of-block verdict, taken from the state after this character
    always_comb
    begin
        rx_crc_ok = 1'b1;
        for (int i = 0; i < HEX_DEPTH; i++)
        begin
            rx_crc_ok = rx_crc_ok && hexw_next[i].ok;
        end
        rx_crc = rx_crc_ok ? {hexw_next[0].val, hexw_next[1].val,
                              hexw_next[2].val, hexw_next[3].val} : 16'd0;

        if (phase_next != PH_DONE)
        begin
            err = ERR_NO_FRAME;
        end
        else if (count_next < COUNT_W'(MIN_BODY))
        begin
            err = ERR_SHORT;
        end
        else if (count_next > COUNT_W'(MAX_BODY_CHARS))
        begin
            err = ERR_LONG;
        end
        else if (rx_crc != crc_next)
        begin
            err = ERR_CRC;
        end
        else if (ferr_next == ERR_TRANS || ferr_next == ERR_PROTO)
        begin
            err = ferr_next;
        end
        else if (len_bad_next ||
                 {1'b0, len_next} != (17'(count_next) + 17'd2))
        begin
            err = ERR_LENGTH;
        end
        else
        begin
            err = ferr_next;
        end

        out_next.frame_ok   = (err == ERR_OK);
        out_next.error_code = err;
        out_next.unit_mode  = (err == ERR_NO_FRAME) ? MODE_NONE : mode_next;

        if (q_pop && in.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            crc_reg       <= CRC_INIT;
            len_reg       <= '0;
            len_bad_reg   <= 1'b0;
            ferr_reg      <= ERR_OK;
            mode_reg      <= MODE_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                if (in.last)
                begin
                    phase_reg   <= PH_HUNT;
                    count_reg   <= '0;
                    crc_reg     <= CRC_INIT;
                    len_reg     <= '0;
                    len_bad_reg <= 1'b0;
                    ferr_reg    <= ERR_OK;
                    mode_reg    <= MODE_NONE;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    count_reg   <= count_next;
                    crc_reg     <= crc_next;
                    len_reg     <= len_next;
                    len_bad_reg <= len_bad_next;
                    ferr_reg    <= ferr_next;
                    mode_reg    <= mode_next;
                end
            end
        end
    end

    // window contents are only read once the body count says they were written
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            win_reg  <= win_next;
            hexw_reg <= hexw_next;
        end
        if (q_pop && in.last)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- hw/rtl/login_reply_frame_check.sv -----
// Top level of the login reply frame checker.
//
// Input stream: one received character per item on s_tdata, s_tlast on the
// last character of a reply block. Output stream: one verdict per block,
// given for the item that carries s_tlast.
// A front end classifies each character into a two-entry queue; the back end
// tracks the frame between the first two colons, runs a CRC-16 (reflected,
// poly A001, init FFFF, each character sign-extended before the XOR) over the
// body less its last seven characters and checks the fixed header fields.
// Throughput: one character per cycle; the back end takes one queue entry a
// cycle except while a block end waits for a held verdict to be taken.
// The verdict reaches m_tvalid through the queue entry written when the last
// character is accepted and then the output register, loaded when the back
// end pops that entry.
// Reset clears the frame state and empties queue and output register.
// A stalled m_tready holds the verdict; characters of the next block keep
// flowing until a second block end reaches the back end, after which the
// queue fills and s_tready drops.
`include "login_reply_frame_check_defines.svh"

module login_reply_frame_check
    import lrfc_pkg::*;
#(
    parameter int MAX_BODY_CHARS = MAX_BODY_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // rx_char[7:0]
    input  logic              s_tlast,   // block_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata    // frame_ok[0], error_code[4:1], unit_mode[7:5]
);

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    char_info_t q_wr_data;
    char_info_t q_rd_data;
    result_t    res;

    lrfc_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wr_data (q_wr_data)
    );

    lrfc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_rd_data)
    );

    lrfc_back #(
        .MAX_BODY_CHARS (MAX_BODY_CHARS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rd_data (q_rd_data),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.unit_mode, res.error_code, res.frame_ok};

    `LRFC_ASSERT_SAME(a_ok_matches_code, m_tvalid, res.frame_ok == (res.error_code == ERR_OK), "frame_ok disagrees with error_code")
    `LRFC_ASSERT_SAME(a_no_frame_mode, m_tvalid && res.error_code == ERR_NO_FRAME, res.unit_mode == MODE_NONE, "unit_mode set without a frame")
    `LRFC_ASSERT_SAME(a_no_push_when_full, q_push, !q_full, "queue written while full")
    `LRFC_ASSERT_NEXT(a_block_end_gives_result, q_pop && q_rd_data.last, m_tvalid, "block end left no result")

endmodule
